@@ src/srb_pkg.sv @@
// Shared types and constants of the binary S-record receiver.
`timescale 1ns / 1ps
`default_nettype none

package srb_pkg;

  // Width of a data length or byte index inside a record (up to 63 bytes).
  localparam int LEN_W = 6;

  localparam logic [7:0] CHAR_S     = 8'h53;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_TWO   = 8'h32;
  localparam logic [7:0] CHAR_THREE = 8'h33;
  localparam logic [7:0] CHAR_SIX   = 8'h36;
  localparam logic [7:0] CHAR_SEVEN = 8'h37;
  localparam logic [7:0] CHAR_EIGHT = 8'h38;

  localparam logic [23:0] COUNT_MAX   = 24'hFFFFFF;
  localparam logic [15:0] COUNT16_MAX = 16'hFFFF;

  localparam logic [2:0] ALEN_SHORT  = 3'd2;
  localparam logic [2:0] ALEN_MEDIUM = 3'd3;
  localparam logic [2:0] ALEN_LONG   = 3'd4;

  localparam logic [3:0] RT_DATA_LO  = 4'd1;
  localparam logic [3:0] RT_DATA_HI  = 4'd3;
  localparam logic [3:0] RT_COUNT16  = 4'd5;
  localparam logic [3:0] RT_COUNT24  = 4'd6;
  localparam logic [3:0] RT_START_LO = 4'd7;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2,
    KIND_STRAY  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_TYPE,
    PH_SIZE,
    PH_ADDR,
    PH_DATA,
    PH_CSUM
  } front_phase_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_FETCH,
    B_WRITE,
    B_FINAL
  } back_state_t;

  // One finished record (or stray byte) handed from the parser to the emitter.
  typedef struct packed {
    kind_t             kind;
    logic [3:0]        rt;
    logic [31:0]       addr;
    logic [LEN_W-1:0]  dlen;
    logic              bank;
    logic              writes;
  } job_t;

  typedef struct packed {
    logic             en;
    logic             bank;
    logic [LEN_W-1:0] idx;
    logic [7:0]       data;
  } mem_wr_t;

  typedef struct packed {
    logic en;
    logic bank;
  } bank_rel_t;

endpackage

`default_nettype wire

@@ src/srb_front.sv @@
// Record parser: takes link bytes, checks records and queues finished jobs.
`timescale 1ns / 1ps
`default_nettype none

module srb_front #(
  parameter int MAX_DATA = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             rx_valid,
  output logic                  rx_ready,
  input  wire logic [7:0]       rx_byte,
  input  wire logic [7:0]       max_size,
  input  wire logic             q_full,
  output logic                  job_push,
  output srb_pkg::job_t         job,
  output srb_pkg::mem_wr_t      wr,
  input  wire srb_pkg::bank_rel_t rel
);

  srb_pkg::front_phase_t phase, phase_next;
  logic [7:0]               type_digit;
  logic [7:0]               size_byte;
  logic [31:0]              address;
  logic [srb_pkg::LEN_W-1:0] byte_index;
  logic [7:0]               running_sum;
  logic                     wbank;
  logic [1:0]               busy;
  logic [1:0]               busy_next;

  logic [2:0]               alen;
  logic [8:0]               diff;
  logic                     dlen_ok;
  logic [srb_pkg::LEN_W-1:0] dlen;
  logic                     digit;
  logic [3:0]               rt;
  logic                     take;
  logic                     good;

  always_comb begin
    if (type_digit == srb_pkg::CHAR_TWO || type_digit == srb_pkg::CHAR_SIX ||
        type_digit == srb_pkg::CHAR_EIGHT) begin
      alen = srb_pkg::ALEN_MEDIUM;
    end else if (type_digit == srb_pkg::CHAR_THREE ||
                 type_digit == srb_pkg::CHAR_SEVEN) begin
      alen = srb_pkg::ALEN_LONG;
    end else begin
      alen = srb_pkg::ALEN_SHORT;
    end
  end

  // Data length is size minus address length minus one; out of range means none.
  assign diff    = {1'b0, size_byte} - {6'd0, alen} - 9'd1;
  assign dlen_ok = !diff[8] && (diff[7:0] != 8'd0) && (diff[7:0] <= 8'(MAX_DATA));
  assign dlen    = dlen_ok ? diff[srb_pkg::LEN_W-1:0] : '0;

  assign digit = (type_digit >= srb_pkg::CHAR_ZERO) && (type_digit <= srb_pkg::CHAR_NINE);
  assign rt    = digit ? type_digit[3:0] : 4'd0;
  assign good  = digit && (size_byte <= max_size) && ((~running_sum) == rx_byte);

  assign rx_ready = !q_full && !(phase == srb_pkg::PH_DATA && busy[wbank]);
  assign take     = rx_valid && rx_ready;

  always_comb begin
    phase_next = phase;
    if (take) begin
      case (phase)
        srb_pkg::PH_HUNT: if (rx_byte == srb_pkg::CHAR_S) phase_next = srb_pkg::PH_TYPE;
        srb_pkg::PH_TYPE: phase_next = srb_pkg::PH_SIZE;
        srb_pkg::PH_SIZE: phase_next = srb_pkg::PH_ADDR;
        srb_pkg::PH_ADDR: begin
          if ({{(srb_pkg::LEN_W-3){1'b0}}, alen} == byte_index + 1'b1) begin
            phase_next = (dlen != '0) ? srb_pkg::PH_DATA : srb_pkg::PH_CSUM;
          end
        end
        srb_pkg::PH_DATA: if (byte_index + 1'b1 == dlen) phase_next = srb_pkg::PH_CSUM;
        srb_pkg::PH_CSUM: phase_next = srb_pkg::PH_HUNT;
        default: phase_next = srb_pkg::PH_HUNT;
      endcase
    end
  end

  always_comb begin
    job_push   = 1'b0;
    job.kind   = srb_pkg::KIND_STRAY;
    job.rt     = 4'd0;
    job.addr   = address;
    job.dlen   = dlen;
    job.bank   = wbank;
    job.writes = 1'b0;
    wr.en      = 1'b0;
    wr.bank    = wbank;
    wr.idx     = byte_index;
    wr.data    = rx_byte;
    case (phase)
      srb_pkg::PH_HUNT: job_push = take && (rx_byte != srb_pkg::CHAR_S);
      srb_pkg::PH_DATA: wr.en = take;
      srb_pkg::PH_CSUM: begin
        job_push   = take;
        job.rt     = rt;
        job.kind   = good ? srb_pkg::KIND_ACCEPT : srb_pkg::KIND_REJECT;
        job.writes = good && (rt >= srb_pkg::RT_DATA_LO) && (rt <= srb_pkg::RT_DATA_HI) &&
                     (dlen != '0);
      end
      default: job_push = 1'b0;
    endcase
  end

  // A bank stays busy until the emitter has read out its write burst.
  always_comb begin
    busy_next = busy;
    if (rel.en) busy_next[rel.bank] = 1'b0;
    if (job_push && job.writes) busy_next[wbank] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= srb_pkg::PH_HUNT;
      type_digit  <= 8'd0;
      size_byte   <= 8'd0;
      address     <= 32'd0;
      byte_index  <= '0;
      running_sum <= 8'd0;
      wbank       <= 1'b0;
      busy        <= 2'b00;
    end else begin
      phase <= phase_next;
      if (take) begin
        case (phase)
          srb_pkg::PH_TYPE: type_digit <= rx_byte;
          srb_pkg::PH_SIZE: begin
            size_byte   <= rx_byte;
            running_sum <= rx_byte;
            address     <= 32'd0;
            byte_index  <= '0;
          end
          srb_pkg::PH_ADDR: begin
            address     <= {address[23:0], rx_byte};
            running_sum <= running_sum + rx_byte;
            byte_index  <= (phase_next == srb_pkg::PH_ADDR) ? byte_index + 1'b1 : '0;
          end
          srb_pkg::PH_DATA: begin
            running_sum <= running_sum + rx_byte;
            byte_index  <= byte_index + 1'b1;
          end
          default: running_sum <= running_sum;
        endcase
      end
      busy <= busy_next;
      if (job_push && job.writes) begin
        wbank <= ~wbank;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/srb_queue.sv @@
// Two-entry job queue between the parser and the result emitter.
`timescale 1ns / 1ps
`default_nettype none

module srb_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire srb_pkg::job_t push_job,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output srb_pkg::job_t      head_job
);

  srb_pkg::job_t slots [2];
  logic          wptr;
  logic          rptr;
  logic [1:0]    count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_job   = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

@@ src/srb_back.sv @@
// Result emitter: data buffer, write bursts, record counter and output register.
`timescale 1ns / 1ps
`default_nettype none

module srb_back #(
  parameter int MAX_DATA = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire srb_pkg::mem_wr_t wr,
  input  wire logic             q_valid,
  input  wire srb_pkg::job_t    q_job,
  output logic                  q_pop,
  output srb_pkg::bank_rel_t    rel,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output srb_pkg::kind_t        out_kind,
  output logic [31:0]           out_write_address,
  output logic [7:0]            out_write_byte,
  output logic [3:0]            out_record_type,
  output logic                  out_count_mismatch,
  output logic [31:0]           out_entry_address,
  output logic                  out_end_of_download,
  output logic                  out_last
);

  localparam int IW = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;

  // Two banks so the parser can fill one record while the other drains.
  logic [7:0] mem [2**(IW+1)];
  logic [7:0] rd_data;

  srb_pkg::back_state_t     state, state_next;
  srb_pkg::job_t            job_r;
  logic [srb_pkg::LEN_W-1:0] idx;
  logic [23:0]              count;
  logic                     out_free;
  logic                     load_write;
  logic                     load_final;

  srb_pkg::kind_t f_kind;
  logic           f_mm;
  logic [31:0]    f_sa;
  logic           f_eod;
  logic           is_data_rec;

  always_ff @(posedge clk) begin
    if (wr.en) mem[{wr.bank, wr.idx[IW-1:0]}] <= wr.data;
    rd_data <= mem[{job_r.bank, idx[IW-1:0]}];
  end

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      srb_pkg::B_IDLE:  if (q_valid) state_next = q_job.writes ? srb_pkg::B_FETCH : srb_pkg::B_FINAL;
      srb_pkg::B_FETCH: state_next = srb_pkg::B_WRITE;
      srb_pkg::B_WRITE: begin
        if (out_free) begin
          state_next = (idx + 1'b1 == job_r.dlen) ? srb_pkg::B_FINAL : srb_pkg::B_FETCH;
        end
      end
      srb_pkg::B_FINAL: if (out_free) state_next = srb_pkg::B_IDLE;
      default: state_next = srb_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = (state == srb_pkg::B_IDLE) && q_valid;
    load_write = (state == srb_pkg::B_WRITE) && out_free;
    load_final = (state == srb_pkg::B_FINAL) && out_free;
    rel.en     = load_final && job_r.writes;
    rel.bank   = job_r.bank;
  end

  assign is_data_rec = (job_r.rt >= srb_pkg::RT_DATA_LO) && (job_r.rt <= srb_pkg::RT_DATA_HI);

  always_comb begin
    f_kind = job_r.kind;
    f_mm   = 1'b0;
    f_sa   = 32'd0;
    f_eod  = 1'b0;
    if (job_r.kind == srb_pkg::KIND_ACCEPT) begin
      if (job_r.rt == srb_pkg::RT_COUNT16) begin
        f_mm = ({8'd0, job_r.addr[15:0] & srb_pkg::COUNT16_MAX}) != count;
      end else if (job_r.rt == srb_pkg::RT_COUNT24) begin
        f_mm = (job_r.addr[23:0] & srb_pkg::COUNT_MAX) != count;
      end else if (job_r.rt >= srb_pkg::RT_START_LO) begin
        f_sa  = job_r.addr;
        f_eod = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) job_r <= q_job;
    if (q_pop) begin
      idx <= '0;
    end else if (load_write) begin
      idx <= idx + 1'b1;
    end
    if (load_write) begin
      out_kind            <= srb_pkg::KIND_WRITE;
      out_write_address   <= job_r.addr + {{(32-srb_pkg::LEN_W){1'b0}}, idx};
      out_write_byte      <= rd_data;
      out_record_type     <= job_r.rt;
      out_count_mismatch  <= 1'b0;
      out_entry_address   <= 32'd0;
      out_end_of_download <= 1'b0;
      out_last            <= 1'b0;
    end else if (load_final) begin
      out_kind            <= f_kind;
      out_write_address   <= 32'd0;
      out_write_byte      <= 8'd0;
      out_record_type     <= job_r.rt;
      out_count_mismatch  <= f_mm;
      out_entry_address   <= f_sa;
      out_end_of_download <= f_eod;
      out_last            <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= srb_pkg::B_IDLE;
      out_valid <= 1'b0;
      count     <= 24'd0;
    end else begin
      state <= state_next;
      if (load_write || load_final) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (load_final && job_r.kind == srb_pkg::KIND_ACCEPT) begin
        if (is_data_rec && count != srb_pkg::COUNT_MAX) begin
          count <= count + 24'd1;
        end else if (job_r.rt >= srb_pkg::RT_START_LO) begin
          count <= 24'd0;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ src/srecord_binary_receiver.sv @@
// Top level of the binary S-record receiver.
//
//   channel   direction  handshake            payload
//   s_axis    in         s_tvalid / s_tready  s_tdata: rx_byte
//   m_axis    out        m_tvalid / m_tready  m_tdata, m_tuser: kind, m_tlast: last
//   cfg       in         cfg_valid/cfg_ready  cfg_data: max_record_size
//
// The parser takes one word per cycle. A record's results leave through a
// registered output: the job is popped from the queue, each data write takes a
// buffer read, then a load, and the closing accept or reject follows; the
// write pace is set by the registered buffer read. A two-entry job queue lets
// the parser run ahead; it stalls when the queue is full, or on a data byte
// while both data banks hold undelivered writes. Synchronous reset clears all
// control state and sets max_record_size to 37.
`timescale 1ns / 1ps
`default_nettype none

module srecord_binary_receiver #(
  parameter int MAX_DATA = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [79:0]      m_tdata,   // [31:0] write_address, [39:32] write_byte,
                                      // [43:40] record_type, [44] count_mismatch,
                                      // [76:45] entry_address, [77] end_of_download
  output logic [1:0]       m_tuser,   // [1:0] kind
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data
);

  logic [7:0]          max_size;
  logic                q_full;
  logic                q_push;
  logic                q_pop;
  logic                q_valid;
  srb_pkg::job_t       push_job;
  srb_pkg::job_t       head_job;
  srb_pkg::mem_wr_t    wr;
  srb_pkg::bank_rel_t  rel;
  srb_pkg::kind_t      out_kind;
  logic [31:0]         out_write_address;
  logic [7:0]          out_write_byte;
  logic [3:0]          out_record_type;
  logic                out_count_mismatch;
  logic [31:0]         out_entry_address;
  logic                out_end_of_download;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_size <= 8'd37;
    end else if (cfg_valid && cfg_ready) begin
      max_size <= cfg_data;
    end
  end

  srb_front #(.MAX_DATA(MAX_DATA)) u_front (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (s_tvalid),
    .rx_ready (s_tready),
    .rx_byte  (s_tdata),
    .max_size (max_size),
    .q_full   (q_full),
    .job_push (q_push),
    .job      (push_job),
    .wr       (wr),
    .rel      (rel)
  );

  srb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (head_job)
  );

  srb_back #(.MAX_DATA(MAX_DATA)) u_back (
    .clk                 (clk),
    .rst                 (rst),
    .wr                  (wr),
    .q_valid             (q_valid),
    .q_job               (head_job),
    .q_pop               (q_pop),
    .rel                 (rel),
    .out_valid           (m_tvalid),
    .out_ready           (m_tready),
    .out_kind            (out_kind),
    .out_write_address   (out_write_address),
    .out_write_byte      (out_write_byte),
    .out_record_type     (out_record_type),
    .out_count_mismatch  (out_count_mismatch),
    .out_entry_address   (out_entry_address),
    .out_end_of_download (out_end_of_download),
    .out_last            (m_tlast)
  );

  assign m_tuser = out_kind;
  assign m_tdata = {2'b00, out_end_of_download, out_entry_address, out_count_mismatch,
                    out_record_type, out_write_byte, out_write_address};

  // A data write is never the final word of a burst.
  a_write_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == srb_pkg::KIND_WRITE) |-> !m_tlast)
    else $error("data write word carries tlast");

  // The parser never pushes a job into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("job pushed into full queue");

  // End of download only appears on the closing accept of a record.
  a_eod_on_accept: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_end_of_download |-> (m_tuser == srb_pkg::KIND_ACCEPT) && m_tlast)
    else $error("end of download on a word that is not a final accept");

  // A bank is never released in the same cycle as a new job is popped.
  a_release_after_write: assert property (@(posedge clk) disable iff (rst)
    rel.en |-> q_pop == 1'b0)
    else $error("bank released while a new job is popped");

endmodule

`default_nettype wire
